>>> rtl/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared types, constants and the sine table generator for the SPWM core.
// ----------------------------------------------------------------------------
package spwm_pkg;

	localparam int POS_W     = 10;  // phase position width (table up to 1024 steps)
	localparam int SPEED_W   = 8;   // signed speed step
	localparam int SPEED_LIM = 100; // steps beyond +/- this are dropped
	localparam int GAIN_W    = 9;
	localparam int SINE_W    = 16;  // Q1.15 sine sample
	localparam int SINE_FULL = 32767;

	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(128);

	// floor(2*pi * 2^30), angle scale for the series below
	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

	typedef logic [POS_W-1:0] pos_t;

	// table addresses of the three phases
	typedef struct packed {
		pos_t a;
		pos_t b;
		pos_t c;
	} spwm_addr_t;

	// Sine of a Q32 fraction of a turn, Q1.15 result. Used only to build
	// constant ROM contents at elaboration. Odd Taylor series to x^11 in
	// Q30, each term truncated.
	function automatic logic signed [SINE_W-1:0] sine_q15(input logic [31:0] p);
		logic [1:0]         quad;
		logic [63:0]        r;
		logic [63:0]        f;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        t;
		logic signed [63:0] acc;
		logic signed [63:0] v;
		quad = p[31:30];
		r    = {34'd0, p[29:0]};
		f    = quad[0] ? ((64'd1 << 30) - r) : r;
		x    = (f * TWO_PI_Q30) >> 32;
		x2   = (x * x) >> 30;
		acc  = $signed(x);
		t    = ((x * x2) >> 30) / 64'd6;
		acc  = acc - $signed(t);
		t    = ((t * x2) >> 30) / 64'd20;
		acc  = acc + $signed(t);
		t    = ((t * x2) >> 30) / 64'd42;
		acc  = acc - $signed(t);
		t    = ((t * x2) >> 30) / 64'd72;
		acc  = acc + $signed(t);
		t    = ((t * x2) >> 30) / 64'd110;
		acc  = acc - $signed(t);
		if (acc < 0) begin
			acc = 64'sd0;
		end
		v = (acc * 64'sd32767 + 64'sd536870912) >>> 30;
		if (v > 64'(SINE_FULL)) begin
			v = 64'(SINE_FULL);
		end
		return quad[1] ? -SINE_W'(v) : SINE_W'(v);
	endfunction

endpackage

>>> rtl/spwm_phase.sv
// ----------------------------------------------------------------------------
// spwm_phase
// Phase position register with modulo wrap and the three table addresses.
// ----------------------------------------------------------------------------
module spwm_phase #(
	parameter int TABLE_STEPS = 600
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step_en,
	input  logic signed [spwm_pkg::SPEED_W-1:0] speed,
	output spwm_pkg::spwm_addr_t                addr
);

	localparam int OFF_B = TABLE_STEPS / 3;
	localparam int OFF_C = (2 * TABLE_STEPS) / 3;
	localparam int TAB_N = 1 << spwm_pkg::SPEED_W;

	// speed mod TABLE_STEPS for every legal step, indexed by speed + limit
	spwm_pkg::pos_t mod_tab [TAB_N];

	for (genvar j = 0; j < TAB_N; j++) begin : g_mod
		localparam int R = (j <= 2 * spwm_pkg::SPEED_LIM) ?
			(((j - spwm_pkg::SPEED_LIM) % TABLE_STEPS) + TABLE_STEPS) % TABLE_STEPS : 0;
		assign mod_tab[j] = spwm_pkg::POS_W'(R);
	end

	spwm_pkg::pos_t              pos_q;
	logic [spwm_pkg::SPEED_W-1:0] idx;
	spwm_pkg::pos_t              step_r;
	logic [spwm_pkg::POS_W:0]    sum_a;
	logic [spwm_pkg::POS_W:0]    sum_b;
	logic [spwm_pkg::POS_W:0]    sum_c;
	spwm_pkg::pos_t              nxt;

	always_comb begin
		idx    = spwm_pkg::SPEED_W'(speed) + spwm_pkg::SPEED_W'(spwm_pkg::SPEED_LIM);
		step_r = mod_tab[idx];
		sum_a  = {1'b0, pos_q} + {1'b0, step_r};
		nxt    = (sum_a >= (spwm_pkg::POS_W+1)'(TABLE_STEPS)) ?
			spwm_pkg::POS_W'(sum_a - (spwm_pkg::POS_W+1)'(TABLE_STEPS)) :
			spwm_pkg::POS_W'(sum_a);
		sum_b  = {1'b0, nxt} + (spwm_pkg::POS_W+1)'(OFF_B);
		sum_c  = {1'b0, nxt} + (spwm_pkg::POS_W+1)'(OFF_C);
		addr.a = nxt;
		addr.b = (sum_b >= (spwm_pkg::POS_W+1)'(TABLE_STEPS)) ?
			spwm_pkg::POS_W'(sum_b - (spwm_pkg::POS_W+1)'(TABLE_STEPS)) :
			spwm_pkg::POS_W'(sum_b);
		addr.c = (sum_c >= (spwm_pkg::POS_W+1)'(TABLE_STEPS)) ?
			spwm_pkg::POS_W'(sum_c - (spwm_pkg::POS_W+1)'(TABLE_STEPS)) :
			spwm_pkg::POS_W'(sum_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (step_en) begin
			pos_q <= nxt;
		end
	end

endmodule

>>> rtl/spwm_rom.sv
// ----------------------------------------------------------------------------
// spwm_rom
// Single-port sine ROM, one Q1.15 entry per table step, registered read.
// ----------------------------------------------------------------------------
module spwm_rom #(
	parameter int TABLE_STEPS = 600
) (
	input  logic                               clk,
	input  logic                               rd_en,
	input  spwm_pkg::pos_t                     addr,
	output logic signed [spwm_pkg::SINE_W-1:0] data_q
);

	localparam int AW = $clog2(TABLE_STEPS);

	logic signed [spwm_pkg::SINE_W-1:0] rom [TABLE_STEPS];

	for (genvar i = 0; i < TABLE_STEPS; i++) begin : g_rom
		// Q32 turn fraction of entry i
		localparam logic [63:0] PH = (64'(i) << 32) / 64'(TABLE_STEPS);
		assign rom[i] = spwm_pkg::sine_q15(PH[31:0]);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= rom[addr[AW-1:0]];
		end
	end

endmodule

>>> rtl/spwm_duty.sv
// ----------------------------------------------------------------------------
// spwm_duty
// Scale one sine sample by the gain, offset to mid-scale, round and clamp.
// ----------------------------------------------------------------------------
module spwm_duty #(
	parameter int DUTY_BITS = 12
) (
	input  logic [spwm_pkg::GAIN_W-1:0]        gain,
	input  logic signed [spwm_pkg::SINE_W-1:0] sine,
	output logic [DUTY_BITS-1:0]               duty
);

	localparam int SH   = 23 - DUTY_BITS;
	localparam int PW   = spwm_pkg::GAIN_W + 1 + spwm_pkg::SINE_W;
	localparam int VW   = PW + 1;
	localparam int BIAS = (1 << 22) + (1 << (SH - 1));  // mid-scale plus half LSB

	logic signed [PW-1:0] prod;
	logic signed [VW-1:0] v;
	logic [VW-1:0]        d;

	always_comb begin
		prod = $signed({1'b0, gain}) * sine;
		v    = VW'(prod) + VW'(BIAS);
		d    = VW'(v) >> SH;
		if (v[VW-1]) begin
			duty = '0;
		end else if (d > VW'((1 << DUTY_BITS) - 1)) begin
			duty = '1;
		end else begin
			duty = d[DUTY_BITS-1:0];
		end
	end

endmodule

>>> rtl/three_phase_sine_pwm_generator_core.sv
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_generator_core
// Three-phase sine PWM duty generator: phase accumulator, sine ROMs, scaling.
// ----------------------------------------------------------------------------
// Each input word carries a signed speed step. A step within -100..100 moves
// the phase position (modulo TABLE_STEPS) and yields one output word with
// three duties read from a sine table at the position and one and two thirds
// of a turn further on, scaled by power_gain (1/256 of full scale per count)
// around mid-scale. A step outside that range is still taken but changes
// nothing and produces no output word. The core takes one word per clock
// while in_ready is high. An in-range step has its samples read from the
// ROMs into their registered outputs, then scaled by the gain into the
// output register. Back-pressure on the output stalls the two stages, and
// in_ready drops only when both hold a word. The ROM contents are constants,
// so no clearing pass follows reset. power_gain resets to 128; the user must
// write it through the cfg channel only while the core is idle; not enforced.
module three_phase_sine_pwm_generator_core #(
	parameter int TABLE_STEPS = 600,
	parameter int DUTY_BITS   = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input words
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [spwm_pkg::SPEED_W-1:0] speed,
	// output words
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [DUTY_BITS-1:0]                duty_a,
	output logic [DUTY_BITS-1:0]                duty_b,
	output logic [DUTY_BITS-1:0]                duty_c,
	// gain register write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [spwm_pkg::GAIN_W-1:0]         power_gain
);

	logic                                in_fire;
	logic                                in_range;
	logic                                step_en;
	logic                                adv_s2;
	logic                                valid_s1;
	logic [spwm_pkg::GAIN_W-1:0]         gain_q;
	spwm_pkg::spwm_addr_t                addr;
	logic signed [spwm_pkg::SINE_W-1:0]  sin_a_s1;
	logic signed [spwm_pkg::SINE_W-1:0]  sin_b_s1;
	logic signed [spwm_pkg::SINE_W-1:0]  sin_c_s1;
	logic [DUTY_BITS-1:0]                dut_a;
	logic [DUTY_BITS-1:0]                dut_b;
	logic [DUTY_BITS-1:0]                dut_c;

	// output stage moves when empty or being drained; stage 1 follows it
	assign adv_s2    = !out_valid || out_ready;
	assign in_ready  = !valid_s1 || adv_s2;
	assign in_fire   = in_valid && in_ready;
	assign in_range  = (speed >= -spwm_pkg::SPEED_W'(spwm_pkg::SPEED_LIM)) &&
		(speed <= spwm_pkg::SPEED_W'(spwm_pkg::SPEED_LIM));
	assign step_en   = in_fire && in_range;
	assign cfg_ready = 1'b1;

	// gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= spwm_pkg::GAIN_RST;
		end else if (cfg_valid) begin
			gain_q <= power_gain;
		end
	end

	// phase accumulator, gives the addresses of the new position
	spwm_phase #(.TABLE_STEPS(TABLE_STEPS)) u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.speed   (speed),
		.addr    (addr)
	);

	// stage 1: one ROM per phase, read in the accept cycle
	spwm_rom #(.TABLE_STEPS(TABLE_STEPS)) u_rom_a (
		.clk(clk), .rd_en(step_en), .addr(addr.a), .data_q(sin_a_s1)
	);
	spwm_rom #(.TABLE_STEPS(TABLE_STEPS)) u_rom_b (
		.clk(clk), .rd_en(step_en), .addr(addr.b), .data_q(sin_b_s1)
	);
	spwm_rom #(.TABLE_STEPS(TABLE_STEPS)) u_rom_c (
		.clk(clk), .rd_en(step_en), .addr(addr.c), .data_q(sin_c_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= step_en;  // dropped steps leave no word behind
		end
	end

	// stage 2: gain, offset, round, clamp
	spwm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_a (.gain(gain_q), .sine(sin_a_s1), .duty(dut_a));
	spwm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_b (.gain(gain_q), .sine(sin_b_s1), .duty(dut_b));
	spwm_duty #(.DUTY_BITS(DUTY_BITS)) u_duty_c (.gain(gain_q), .sine(sin_c_s1), .duty(dut_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			duty_a <= dut_a;
			duty_b <= dut_b;
			duty_c <= dut_c;
		end
	end

endmodule

>>> rtl/spwm_checker.sv
// ----------------------------------------------------------------------------
// spwm_checker
// Port-level checks on the SPWM core, bound to the top level.
// ----------------------------------------------------------------------------
module spwm_checker #(
	parameter int DUTY_BITS = 12
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic signed [spwm_pkg::SPEED_W-1:0] speed,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [DUTY_BITS-1:0]                duty_a,
	input logic [DUTY_BITS-1:0]                duty_b,
	input logic [DUTY_BITS-1:0]                duty_c
);

	// a new output word comes, through stage 1, from an accepted in-range step
	a_rose_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready &&
			speed >= -8'sd100 && speed <= 8'sd100, 2))
		else $error("output word without a matching in-range step");

	// input stalls only when the output side is full and blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while output side can move");

	// a blocked output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(duty_a) &&
			$stable(duty_b) && $stable(duty_c)))
		else $error("blocked output word changed or dropped");

endmodule

bind three_phase_sine_pwm_generator_core spwm_checker #(.DUTY_BITS(DUTY_BITS)) u_spwm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.speed     (speed),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.duty_a    (duty_a),
	.duty_b    (duty_b),
	.duty_c    (duty_c)
);
